// File: sv/apu_pkg.sv
// apu_pkg: shared widths, fixed-point constants, register codes and beat types
// for the adam parameter update core; no dependencies
package apu_pkg;

    localparam int VAL_W     = 48;
    localparam int RATE_W    = 33;
    localparam int CFG_IDX_W = 2;
    localparam int ROOT_W    = 56;

    // moment decay rates, unsigned q0.32; each pair sums to one
    localparam logic [31:0] BETA1  = 32'd3865470566;
    localparam logic [31:0] CBETA1 = 32'd429496730;
    localparam logic [31:0] BETA2  = 32'd4290672329;
    localparam logic [22:0] CBETA2 = 23'd4294967;
    // epsilon, q16.32
    localparam logic [5:0]  EPS    = 6'd43;

    localparam logic [RATE_W-1:0] LR_RESET  = 33'd4294967;
    localparam logic [RATE_W-1:0] BC1_RESET = 33'd429496730;
    localparam logic [RATE_W-1:0] BC2_RESET = 33'd4294967;

    localparam logic [VAL_W-1:0] S48_MAX = 48'h7fff_ffff_ffff;
    localparam logic [VAL_W-1:0] S48_MIN = 48'h8000_0000_0000;
    localparam logic [VAL_W-1:0] U48_MAX = 48'hffff_ffff_ffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE    = 2'd0,
        CFG_BIAS_CORR_FIRST  = 2'd1,
        CFG_BIAS_CORR_SECOND = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [VAL_W-1:0] gradient;
        logic signed [VAL_W-1:0] first_moment;
        logic        [VAL_W-1:0] second_moment;
        logic signed [VAL_W-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_first_moment;
        logic        [VAL_W-1:0] new_second_moment;
        logic signed [VAL_W-1:0] new_weight;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [RATE_W-1:0]    value;
    } t_cfg_beat;

    // rates as the datapath uses them (zero corrections already forced to one lsb)
    typedef struct packed {
        logic [RATE_W-1:0] lr;
        logic [RATE_W-1:0] bc1;
        logic [RATE_W-1:0] bc2;
    } t_rates;

    // per-item values that ride along the pipeline
    typedef struct packed {
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] mn;
        logic        [VAL_W-1:0] vn;
        logic        [VAL_W-1:0] mmag;
    } t_side;

endpackage

// File: sv/apu_stream_if.sv
// apu_stream_if: valid/ready channel carrying one payload beat
// payload type is set by the instantiating scope; no dependencies
interface apu_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/adam_parameter_update_core.sv
// adam_parameter_update_core: top level with config registers, pipeline stall
// control and the three pipeline sections apu_moments, apu_norm and apu_step;
// depends on apu_pkg, apu_stream_if and the three section modules
//   channel  dir  beat                                     handshake
//   i_in     in   gradient, first_moment, second_moment,   valid/ready
//                 weight
//   o_out    out  new_first_moment, new_second_moment,     valid/ready
//                 new_weight
//   i_cfg    in   index, value                             valid/ready, always ready
//
// one item per clock unless the output is held; 6 moment stages, 28 divider and 28
// square root stages (4 and 2 bits each), 5 setup and 25 divider stages
// (2 quotient bits each) for the step, and the output register.
// a stalled output freezes every stage at once; no beat is lost or repeated.
// reset empties the pipeline and loads the default rates.
module adam_parameter_update_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apu_stream_if.sink    i_in,
    apu_stream_if.source  o_out,
    apu_stream_if.sink    i_cfg
);
    import apu_pkg::*;

    logic [RATE_W-1:0] r_lr, r_bc1, r_bc2;
    t_rates            w_rates;
    logic              w_en;

    logic              w_front_vld, w_norm_vld, w_step_vld;
    t_side             w_front_side, w_norm_side;
    logic [ROOT_W-1:0] w_norm_root;
    t_out_item         w_out_item;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= LR_RESET;
            r_bc1 <= BC1_RESET;
            r_bc2 <= BC2_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_LEARNING_RATE:    r_lr  <= i_cfg.data.value;
                CFG_BIAS_CORR_FIRST:  r_bc1 <= i_cfg.data.value;
                CFG_BIAS_CORR_SECOND: r_bc2 <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // zero corrections act as one lsb
    assign w_rates.lr  = r_lr;
    assign w_rates.bc1 = (r_bc1 == '0) ? RATE_W'(1) : r_bc1;
    assign w_rates.bc2 = (r_bc2 == '0) ? RATE_W'(1) : r_bc2;

    // whole pipeline advances unless the output beat is held
    assign w_en       = !w_step_vld || o_out.ready;
    assign i_in.ready = w_en;

    apu_moments u_moments (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_item  (i_in.data),
        .o_vld   (w_front_vld),
        .o_side  (w_front_side)
    );

    apu_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_front_vld),
        .i_side  (w_front_side),
        .i_rates (w_rates),
        .o_vld   (w_norm_vld),
        .o_side  (w_norm_side),
        .o_root  (w_norm_root)
    );

    apu_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_norm_vld),
        .i_side  (w_norm_side),
        .i_root  (w_norm_root),
        .i_rates (w_rates),
        .o_vld   (w_step_vld),
        .o_item  (w_out_item)
    );

    assign o_out.valid = w_step_vld;
    assign o_out.data  = w_out_item;

`ifndef SYNTHESIS
    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result beat right after reset");

    // a stall freezes the moment stages
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_front_side))
        else $error("moment stage moved during stall");

    // a stall freezes the root stages with their valid bit
    a_norm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_norm_vld && !w_en) |=> (w_norm_vld && $stable(w_norm_root)))
        else $error("root stage moved during stall");
`endif

endmodule

// File: sv/apu_moments.sv
// apu_moments: six-stage front end computing the new first and second moments
// depends on apu_pkg
module apu_moments (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  apu_pkg::t_in_item i_item,
    output logic              o_vld,
    output apu_pkg::t_side    o_side
);
    import apu_pkg::*;

    localparam logic signed [32:0] B1_S  = signed'({1'b0, BETA1});
    localparam logic signed [32:0] CB1_S = signed'({1'b0, CBETA1});

    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;

    logic signed [56:0] r1_pm_hi, r1_pg_hi;
    logic        [55:0] r1_pm_lo, r1_pg_lo, r1_pv_hi, r1_pv_lo;
    logic        [47:0] r1_gabs;
    logic signed [47:0] r1_w, r2_w, r3_w, r4_w, r5_w;
    logic        [81:0] r2_tm;
    logic        [79:0] r2_vp, r3_vp, r4_vp, r5_vp;
    logic        [47:0] r2_hh, r2_hl, r2_ll;
    logic signed [47:0] r3_mn, r4_mn, r5_mn;
    logic        [94:0] r3_sq;
    logic        [54:0] r4_s0, r4_s1;
    logic        [53:0] r4_s2;
    logic        [47:0] r4_mmag, r5_mmag;
    logic        [117:0] r5_c2sq;
    t_side              r6_side;

    logic signed [23:0] w_mh, w_gh;
    logic        [47:0] w_gabs;
    logic               w_m_fits;
    logic        [118:0] w_tv;

    assign w_mh   = i_item.first_moment[47:24];
    assign w_gh   = i_item.gradient[47:24];
    assign w_gabs = i_item.gradient[47] ? 48'(-i_item.gradient) : 48'(i_item.gradient);
    assign w_m_fits = (r2_tm[81:79] == 3'b000) || (r2_tm[81:79] == 3'b111);
    assign w_tv = 119'(r5_c2sq) + (119'(r5_vp) << 32) + (119'(1) << 63);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products of the decay terms, |g|
            r1_pm_hi <= w_mh * B1_S;
            r1_pm_lo <= 56'(i_item.first_moment[23:0]) * 56'(BETA1);
            r1_pg_hi <= w_gh * CB1_S;
            r1_pg_lo <= 56'(i_item.gradient[23:0]) * 56'(CBETA1);
            r1_pv_hi <= 56'(i_item.second_moment[47:24]) * 56'(BETA2);
            r1_pv_lo <= 56'(i_item.second_moment[23:0]) * 56'(BETA2);
            r1_gabs  <= w_gabs;
            r1_w     <= i_item.weight;

            // first moment sum with rounding, square partials
            r2_tm <= (82'(r1_pm_hi) << 24) + 82'(r1_pm_lo)
                   + (82'(r1_pg_hi) << 24) + 82'(r1_pg_lo) + (82'(1) << 31);
            r2_vp <= (80'(r1_pv_hi) << 24) + 80'(r1_pv_lo);
            r2_hh <= 48'(r1_gabs[47:24]) * 48'(r1_gabs[47:24]);
            r2_hl <= 48'(r1_gabs[47:24]) * 48'(r1_gabs[23:0]);
            r2_ll <= 48'(r1_gabs[23:0]) * 48'(r1_gabs[23:0]);
            r2_w  <= r1_w;

            // saturate first moment, assemble g squared
            r3_mn <= w_m_fits ? r2_tm[79:32] : (r2_tm[81] ? S48_MIN : S48_MAX);
            r3_sq <= (95'(r2_hh) << 48) + (95'(r2_hl) << 25) + 95'(r2_ll);
            r3_vp <= r2_vp;
            r3_w  <= r2_w;

            // scale g squared by one minus beta2 in three slices
            r4_s0   <= 55'(r3_sq[31:0]) * 55'(CBETA2);
            r4_s1   <= 55'(r3_sq[63:32]) * 55'(CBETA2);
            r4_s2   <= 54'(r3_sq[94:64]) * 54'(CBETA2);
            r4_mmag <= r3_mn[47] ? 48'(-r3_mn) : 48'(r3_mn);
            r4_mn   <= r3_mn;
            r4_vp   <= r3_vp;
            r4_w    <= r3_w;

            r5_c2sq <= 118'(r4_s0) + (118'(r4_s1) << 32) + (118'(r4_s2) << 64);
            r5_mmag <= r4_mmag;
            r5_mn   <= r4_mn;
            r5_vp   <= r4_vp;
            r5_w    <= r4_w;

            // second moment with rounding and saturation
            r6_side.vn     <= (|w_tv[118:112]) ? U48_MAX : w_tv[111:64];
            r6_side.mn     <= r5_mn;
            r6_side.mmag   <= r5_mmag;
            r6_side.weight <= r5_w;
        end
    end

    assign o_vld  = r6_vld;
    assign o_side = r6_side;

endmodule

// File: sv/apu_norm.sv
// apu_norm: bias-corrected second moment and its square root, one bit-step
// slice per stage (divider then root); depends on apu_pkg
module apu_norm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  apu_pkg::t_side            i_side,
    input  apu_pkg::t_rates           i_rates,
    output logic                      o_vld,
    output apu_pkg::t_side            o_side,
    output logic [apu_pkg::ROOT_W-1:0] o_root
);
    import apu_pkg::*;

    localparam int DV_BITS = 112;
    localparam int DV_PER  = 4;
    localparam int DV_STG  = DV_BITS / DV_PER;
    localparam int SQ_BITS = ROOT_W;
    localparam int SQ_PER  = 2;
    localparam int SQ_STG  = SQ_BITS / SQ_PER;

    typedef struct packed {
        logic [DV_BITS-1:0] x;
        logic [RATE_W-1:0]  rem;
    } t_dv;

    typedef struct packed {
        logic [DV_BITS-1:0] x;
        logic [57:0]        rem;
        logic [ROOT_W-1:0]  root;
    } t_sq;

    // restoring divide steps: numerator shifts out the top, quotient in the bottom
    function automatic t_dv dv_stage(input t_dv s, input logic [RATE_W-1:0] d);
        logic [RATE_W:0] t;
        t_dv             r;
        r = s;
        for (int j = 0; j < DV_PER; j++) begin
            t   = {r.rem, r.x[DV_BITS-1]};
            r.x = {r.x[DV_BITS-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                r.rem  = RATE_W'(t - {1'b0, d});
                r.x[0] = 1'b1;
            end else begin
                r.rem = t[RATE_W-1:0];
            end
        end
        return r;
    endfunction

    // digit-by-digit square root, two radicand bits per step
    function automatic t_sq sq_stage(input t_sq s);
        logic [59:0] t;
        logic [57:0] trial;
        t_sq         r;
        r = s;
        for (int j = 0; j < SQ_PER; j++) begin
            t     = {r.rem, r.x[DV_BITS-1:DV_BITS-2]};
            r.x   = {r.x[DV_BITS-3:0], 2'b00};
            trial = {r.root, 2'b01};
            if (t >= 60'(trial)) begin
                r.rem  = 58'(t - 60'(trial));
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end else begin
                r.rem  = t[57:0];
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic  r_dv_vld  [DV_STG];
    t_dv   r_dv      [DV_STG];
    t_side r_dv_side [DV_STG];
    logic  r_sq_vld  [SQ_STG];
    t_sq   r_sq      [SQ_STG];
    t_side r_sq_side [SQ_STG];

    // divider: v' * 2^64 / bc2
    for (genvar k = 0; k < DV_STG; k++) begin : g_dv
        t_dv   w_src;
        t_side w_side_src;
        logic  w_vld_src;
        if (k == 0) begin : g_head
            assign w_src      = '{x: {i_side.vn, 64'd0}, rem: '0};
            assign w_side_src = i_side;
            assign w_vld_src  = i_vld;
        end else begin : g_body
            assign w_src      = r_dv[k-1];
            assign w_side_src = r_dv_side[k-1];
            assign w_vld_src  = r_dv_vld[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[k] <= w_vld_src;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k]      <= dv_stage(w_src, i_rates.bc2);
                r_dv_side[k] <= w_side_src;
            end
        end
    end

    // square root of the quotient
    for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
        t_sq   w_src;
        t_side w_side_src;
        logic  w_vld_src;
        if (k == 0) begin : g_head
            assign w_src      = '{x: r_dv[DV_STG-1].x, rem: '0, root: '0};
            assign w_side_src = r_dv_side[DV_STG-1];
            assign w_vld_src  = r_dv_vld[DV_STG-1];
        end else begin : g_body
            assign w_src      = r_sq[k-1];
            assign w_side_src = r_sq_side[k-1];
            assign w_vld_src  = r_sq_vld[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[k] <= w_vld_src;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k]      <= sq_stage(w_src);
                r_sq_side[k] <= w_side_src;
            end
        end
    end

    assign o_vld  = r_sq_vld[SQ_STG-1];
    assign o_side = r_sq_side[SQ_STG-1];
    assign o_root = r_sq[SQ_STG-1].root;

endmodule

// File: sv/apu_step.sv
// apu_step: weight step lr*m/(bc1*d) by a bit-serial pipelined divider,
// then the saturated weight update into the output register; depends on apu_pkg
module apu_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  apu_pkg::t_side             i_side,
    input  logic [apu_pkg::ROOT_W-1:0] i_root,
    input  apu_pkg::t_rates            i_rates,
    output logic                       o_vld,
    output apu_pkg::t_out_item         o_item
);
    import apu_pkg::*;

    localparam int DEN_W  = 90;
    localparam int NUM_W  = 113;
    localparam int DQ_BITS = 49;
    localparam int DQ_PER  = 2;
    localparam int DQ_STG  = (DQ_BITS + DQ_PER - 1) / DQ_PER;

    typedef struct packed {
        logic [DQ_BITS-1:0] x;
        logic [DEN_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic               ovf;
    } t_dq;

    // restoring divide steps over the low numerator bits
    function automatic t_dq dq_stage(input t_dq s, input int cnt);
        logic [DEN_W:0] t;
        t_dq            r;
        r = s;
        for (int j = 0; j < DQ_PER; j++) begin
            if (j < cnt) begin
                t   = {r.rem, r.x[DQ_BITS-1]};
                r.x = {r.x[DQ_BITS-2:0], 1'b0};
                if (t >= {1'b0, r.den}) begin
                    r.rem  = DEN_W'(t - {1'b0, r.den});
                    r.x[0] = 1'b1;
                end else begin
                    r.rem = t[DEN_W-1:0];
                end
            end
        end
        return r;
    endfunction

    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r_out_vld;
    t_side r1_side, r2_side, r3_side, r4_side, r5_side;

    logic [56:0]      r1_d, r1_nh, r1_nl;
    logic [61:0]      r2_dh;
    logic [60:0]      r2_dl;
    logic [80:0]      r2_nm, r3_nm;
    logic [DEN_W-1:0] r3_den, r4_den;
    logic [NUM_W-1:0] r4_num;
    t_dq              r5_dq;
    t_out_item        r_out_item;

    logic  r_dq_vld  [DQ_STG];
    t_dq   r_dq      [DQ_STG];
    t_side r_dq_side [DQ_STG];

    // front stages: denominator bc1*d and numerator |m'|*lr*2^32 + den/2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= 57'(i_root) + 57'(EPS);
            r1_nh   <= 57'(i_side.mmag[47:24]) * 57'(i_rates.lr);
            r1_nl   <= 57'(i_side.mmag[23:0]) * 57'(i_rates.lr);
            r1_side <= i_side;

            r2_dh   <= 62'(i_rates.bc1) * 62'(r1_d[56:28]);
            r2_dl   <= 61'(i_rates.bc1) * 61'(r1_d[27:0]);
            r2_nm   <= (81'(r1_nh) << 24) + 81'(r1_nl);
            r2_side <= r1_side;

            r3_den  <= (DEN_W'(r2_dh) << 28) + DEN_W'(r2_dl);
            r3_nm   <= r2_nm;
            r3_side <= r2_side;

            r4_num  <= {r3_nm, 32'd0} + NUM_W'(r3_den >> 1);
            r4_den  <= r3_den;
            r4_side <= r3_side;

            // quotient above 2^49 can only saturate
            r5_dq.ovf <= DEN_W'(r4_num[NUM_W-1:DQ_BITS]) >= r4_den;
            r5_dq.rem <= DEN_W'(r4_num[NUM_W-1:DQ_BITS]);
            r5_dq.x   <= r4_num[DQ_BITS-1:0];
            r5_dq.den <= r4_den;
            r5_side   <= r4_side;
        end
    end

    // divider slices
    for (genvar k = 0; k < DQ_STG; k++) begin : g_dq
        localparam int CNT = (DQ_BITS - k * DQ_PER < DQ_PER) ? DQ_BITS - k * DQ_PER : DQ_PER;
        t_dq   w_src;
        t_side w_side_src;
        logic  w_vld_src;
        if (k == 0) begin : g_head
            assign w_src      = r5_dq;
            assign w_side_src = r5_side;
            assign w_vld_src  = r5_vld;
        end else begin : g_body
            assign w_src      = r_dq[k-1];
            assign w_side_src = r_dq_side[k-1];
            assign w_vld_src  = r_dq_vld[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dq_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_dq_vld[k] <= w_vld_src;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k]      <= dq_stage(w_src, CNT);
                r_dq_side[k] <= w_side_src;
            end
        end
    end

    // step cap and saturated weight update
    t_dq         w_last;
    t_side       w_last_side;
    logic [48:0] w_step;
    logic [49:0] w_tw;

    assign w_last      = r_dq[DQ_STG-1];
    assign w_last_side = r_dq_side[DQ_STG-1];
    assign w_step = (w_last.ovf || (w_last.x[48] && (|w_last.x[47:0])))
                  ? 49'(1) << 48 : w_last.x;
    assign w_tw   = w_last_side.mn[47] ? 50'(w_last_side.weight) + 50'(w_step)
                                       : 50'(w_last_side.weight) - 50'(w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_dq_vld[DQ_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_item.new_first_moment  <= w_last_side.mn;
            r_out_item.new_second_moment <= w_last_side.vn;
            if ((w_tw[49:47] == 3'b000) || (w_tw[49:47] == 3'b111)) begin
                r_out_item.new_weight <= w_tw[47:0];
            end else begin
                r_out_item.new_weight <= w_tw[49] ? S48_MIN : S48_MAX;
            end
        end
    end

    assign o_vld  = r_out_vld;
    assign o_item = r_out_item;

endmodule
